[rtl/sbf_pkg.sv]
// Shared types and constants for the segmented byte FIFO.
`default_nettype none
package sbf_pkg;

  // Item kind codes
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Fixed field widths
  localparam int DATA_W  = 8;
  localparam int COUNT_W = 11;
  localparam int CFG_W   = 9;

  // Segment length after reset
  localparam logic [CFG_W-1:0] SEG_LEN_RESET = 9'd256;

  // Result queue depth and its pointer/level widths
  localparam int RESQ_DEPTH = 3;
  localparam int RESQ_PTR_W = 2;
  localparam int RESQ_LVL_W = 2;

  // Per-item status handed from the control stage to the result stage
  typedef struct packed {
    logic               done;
    logic               read_hit;
    logic [COUNT_W-1:0] bytes_stored;
  } sbf_ctl_t;

  // One result beat
  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic               done_res;
    logic [COUNT_W-1:0] bytes_stored;
  } sbf_res_t;

endpackage
`default_nettype wire

[rtl/sbf_if.sv]
// Channel interfaces for the segmented byte FIFO: items, results, configuration.
`default_nettype none
interface sbf_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] write_data;
  modport source (output valid, kind, write_data, input ready);
  modport sink   (input valid, kind, write_data, output ready);
endinterface

interface sbf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        done_res;
  logic [10:0] bytes_stored;
  modport source (output valid, read_data, done_res, bytes_stored, input ready);
  modport sink   (input valid, read_data, done_res, bytes_stored, output ready);
endinterface

interface sbf_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] segment_length;
  modport source (output valid, segment_length, input ready);
  modport sink   (input valid, segment_length, output ready);
endinterface
`default_nettype wire

[rtl/sbf_ram.sv]
// Byte store: one-port RAM with registered read data.
`default_nettype none
module sbf_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic                      re,
  input  wire logic [ADDR_W-1:0]         addr,
  input  wire logic [sbf_pkg::DATA_W-1:0] wdata,
  output logic      [sbf_pkg::DATA_W-1:0] rdata
);
  import sbf_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  // Write or read one byte; hold read data otherwise
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

[rtl/sbf_ctrl.sv]
// Segment pointers, occupancy and byte count; decides each item and addresses the store.
`default_nettype none
module sbf_ctrl #(
  parameter int SEGMENTS      = 4,
  parameter int SEGMENT_BYTES = 256,
  parameter int ADDR_W        = 10
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     accept,
  input  wire logic                     kind,
  input  wire logic [sbf_pkg::CFG_W-1:0] seg_len,
  output logic                          mem_we,
  output logic                          mem_re,
  output logic      [ADDR_W-1:0]        mem_addr,
  output sbf_pkg::sbf_ctl_t             ctl
);
  import sbf_pkg::*;

  localparam int SEG_W  = $clog2(SEGMENTS);
  localparam int OFF_W  = (SEGMENT_BYTES > 1) ? $clog2(SEGMENT_BYTES) : 1;
  localparam int LEN_W  = ($clog2(SEGMENT_BYTES + 1) > CFG_W) ?
                          $clog2(SEGMENT_BYTES + 1) : CFG_W;
  localparam int OCC_W  = $clog2(SEGMENTS + 1);
  localparam int CNT_W  = $clog2(SEGMENTS * SEGMENT_BYTES + 1);
  localparam logic [ADDR_W-1:0] SEG_STRIDE = ADDR_W'(SEGMENT_BYTES);
  localparam logic [SEG_W-1:0]  SEG_LAST   = SEG_W'(SEGMENTS - 1);
  localparam logic [OCC_W-1:0]  OCC_FULL   = OCC_W'(SEGMENTS);
  localparam logic [LEN_W-1:0]  LEN_MAX    = LEN_W'(SEGMENT_BYTES);

  logic [SEG_W-1:0] wr_seg, wr_seg_next, rd_seg, rd_seg_next;
  logic [OFF_W-1:0] wr_off, wr_off_next, rd_off, rd_off_next;
  logic [OCC_W-1:0] occ, occ_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  logic [LEN_W-1:0] len, len_raw, wr_off_inc, rd_off_inc;
  logic             wr_start, wr_ok, rd_ok, wr_wrap, rd_wrap;

  // Clamp the configured segment length into 1..SEGMENT_BYTES
  always_comb begin
    len_raw = LEN_W'(seg_len);
    if (len_raw == '0) begin
      len = LEN_W'(1);
    end else if (len_raw > LEN_MAX) begin
      len = LEN_MAX;
    end else begin
      len = len_raw;
    end
  end

  // Decide the item against the current pointers
  always_comb begin
    wr_start   = (wr_off == '0);
    wr_ok      = (kind == KIND_WRITE) && !(wr_start && (occ >= OCC_FULL));
    rd_ok      = (kind == KIND_READ) && (cnt != '0);
    wr_off_inc = LEN_W'(wr_off) + LEN_W'(1);
    rd_off_inc = LEN_W'(rd_off) + LEN_W'(1);
    wr_wrap    = (wr_off_inc >= len);
    rd_wrap    = (rd_off_inc >= len);
  end

  // Compute next pointer state
  always_comb begin
    wr_seg_next = wr_seg;
    wr_off_next = wr_off;
    rd_seg_next = rd_seg;
    rd_off_next = rd_off;
    occ_next    = occ;
    cnt_next    = cnt;
    if (wr_ok) begin
      if (wr_start && (occ < OCC_FULL)) begin
        occ_next = occ + OCC_W'(1);
      end
      cnt_next = cnt + CNT_W'(1);
      if (wr_wrap) begin
        wr_off_next = '0;
        wr_seg_next = (wr_seg == SEG_LAST) ? '0 : wr_seg + SEG_W'(1);
      end else begin
        wr_off_next = OFF_W'(wr_off_inc);
      end
    end
    if (rd_ok) begin
      cnt_next = cnt - CNT_W'(1);
      if (rd_wrap) begin
        rd_off_next = '0;
        rd_seg_next = (rd_seg == SEG_LAST) ? '0 : rd_seg + SEG_W'(1);
        if (occ != '0) begin
          occ_next = occ - OCC_W'(1);
        end
      end else begin
        rd_off_next = OFF_W'(rd_off_inc);
      end
    end
  end

  // Advance pointers on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_seg <= '0;
      wr_off <= '0;
      rd_seg <= '0;
      rd_off <= '0;
      occ    <= '0;
      cnt    <= '0;
    end else if (accept) begin
      wr_seg <= wr_seg_next;
      wr_off <= wr_off_next;
      rd_seg <= rd_seg_next;
      rd_off <= rd_off_next;
      occ    <= occ_next;
      cnt    <= cnt_next;
    end
  end

  // Drive the store and the per-item status
  always_comb begin
    mem_we = accept && wr_ok;
    mem_re = accept && rd_ok;
    if (kind == KIND_WRITE) begin
      mem_addr = ADDR_W'(wr_seg) * SEG_STRIDE + ADDR_W'(wr_off);
    end else begin
      mem_addr = ADDR_W'(rd_seg) * SEG_STRIDE + ADDR_W'(rd_off);
    end
    ctl.done         = wr_ok || rd_ok;
    ctl.read_hit     = rd_ok;
    ctl.bytes_stored = COUNT_W'(cnt_next);
  end

endmodule
`default_nettype wire

[rtl/sbf_resq.sv]
// Small result queue that decouples the output channel from the item pipeline.
`default_nettype none
module sbf_resq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire sbf_pkg::sbf_res_t push_res,
  input  wire logic              in_flight,
  output logic                   space_ok,
  output logic                   head_valid,
  output sbf_pkg::sbf_res_t      head_res,
  input  wire logic              pop
);
  import sbf_pkg::*;

  localparam logic [RESQ_PTR_W-1:0] PTR_LAST = RESQ_PTR_W'(RESQ_DEPTH - 1);

  sbf_res_t              slots [RESQ_DEPTH];
  logic [RESQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [RESQ_LVL_W-1:0] level, level_next;
  logic [RESQ_LVL_W:0]   committed;

  // Count entries plus the one still in flight
  always_comb begin
    committed  = (RESQ_LVL_W + 1)'(level) + (RESQ_LVL_W + 1)'(in_flight);
    space_ok   = (committed < (RESQ_LVL_W + 1)'(RESQ_DEPTH));
    head_valid = (level != '0);
    head_res   = slots[rd_ptr];
    level_next = level;
    case ({push, pop && head_valid})
      2'b10:   level_next = level + RESQ_LVL_W'(1);
      2'b01:   level_next = level - RESQ_LVL_W'(1);
      default: level_next = level;
    endcase
  end

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_res;
    end
  end

  // Advance pointers and level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + RESQ_PTR_W'(1);
      end
      if (pop && head_valid) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + RESQ_PTR_W'(1);
      end
      level <= level_next;
    end
  end

endmodule
`default_nettype wire

[rtl/segmented_byte_fifo.sv]
// Segmented byte FIFO top level.
//
// Channels: src carries items (kind 0 reads one byte, kind 1 writes write_data);
// dst returns one result beat per item (read_data, done_res, bytes_stored);
// cfg writes segment_length (bytes used per segment, 0 acts as 1, values above
// SEGMENT_BYTES act as SEGMENT_BYTES). cfg is always ready; write it while idle.
// Throughput: one item per cycle while dst keeps taking beats. Each item's
// byte store read is registered alongside its status, then the result beat is
// written into a result queue slot, from which dst takes it.
// A write is refused (done_res 0) only when it would open a new segment while
// all SEGMENTS segments are occupied; a read of an empty FIFO gives done_res 0.
// Stalls: up to three results queue behind dst; src.ready then drops until
// dst takes a beat. src.ready depends only on registers.
// Reset: pointers, occupancy and byte count clear, segment_length returns to
// 256. The byte store is not cleared and needs no clearing pass; the block
// accepts items in the first cycle after reset.
`default_nettype none
module segmented_byte_fifo #(
  parameter int SEGMENTS      = 4,
  parameter int SEGMENT_BYTES = 256
) (
  input  wire logic  clk,
  input  wire logic  rst,
  sbf_in_if.sink     src,
  sbf_out_if.source  dst,
  sbf_cfg_if.sink    cfg
);
  import sbf_pkg::*;

  localparam int DEPTH  = SEGMENTS * SEGMENT_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [CFG_W-1:0]  seg_len;
  logic              accept;
  logic              space_ok;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [DATA_W-1:0] mem_rdata;
  sbf_ctl_t          ctl, ctl1;
  logic              v1;
  sbf_res_t          push_res, head_res;
  logic              head_valid;

  assign accept    = src.valid && src.ready;
  assign src.ready = space_ok;
  assign cfg.ready = 1'b1;

  // Hold the segment length register
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_len <= SEG_LEN_RESET;
    end else if (cfg.valid) begin
      seg_len <= cfg.segment_length;
    end
  end

  sbf_ctrl #(
    .SEGMENTS      (SEGMENTS),
    .SEGMENT_BYTES (SEGMENT_BYTES),
    .ADDR_W        (ADDR_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .kind     (src.kind),
    .seg_len  (seg_len),
    .mem_we   (mem_we),
    .mem_re   (mem_re),
    .mem_addr (mem_addr),
    .ctl      (ctl)
  );

  sbf_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (src.write_data),
    .rdata (mem_rdata)
  );

  // Register item status alongside the store read
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctl1 <= ctl;
    end
  end

  // Form the result beat; zero data unless a read succeeded
  always_comb begin
    push_res.read_data    = ctl1.read_hit ? mem_rdata : '0;
    push_res.done_res     = ctl1.done;
    push_res.bytes_stored = ctl1.bytes_stored;
  end

  sbf_resq u_resq (
    .clk        (clk),
    .rst        (rst),
    .push       (v1),
    .push_res   (push_res),
    .in_flight  (v1),
    .space_ok   (space_ok),
    .head_valid (head_valid),
    .head_res   (head_res),
    .pop        (dst.ready)
  );

  assign dst.valid        = head_valid;
  assign dst.read_data    = head_res.read_data;
  assign dst.done_res     = head_res.done_res;
  assign dst.bytes_stored = head_res.bytes_stored;

  // Every accepted beat reaches the result stage in the next cycle
  a_accept_to_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> v1) else $error("accepted beat did not reach result stage");

  // A refused item carries zero data
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (dst.valid && !dst.done_res) |-> (dst.read_data == '0))
    else $error("refused item returned nonzero data");

  // A successful read is always reported as done
  a_read_hit_done: assert property (@(posedge clk) disable iff (rst)
    (v1 && ctl1.read_hit) |-> ctl1.done)
    else $error("read hit without done");

  // Store is never written and read for the same beat
  a_single_port_op: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re)) else $error("store written and read together");

endmodule
`default_nettype wire

[test/segmented_byte_fifo_test.sv]
// Testbench for segmented_byte_fifo: directed and random traffic checked against a shadow FIFO.
`timescale 1ns / 1ps
module segmented_byte_fifo_test;
  import sbf_pkg::*;

  localparam int SEGMENTS      = 4;
  localparam int SEGMENT_BYTES = 256;
  localparam int CYCLE_LIMIT   = 500000;

  logic clk;
  logic rst;

  sbf_in_if  in_ch ();
  sbf_out_if out_ch ();
  sbf_cfg_if cfg_ch ();

  segmented_byte_fifo #(
    .SEGMENTS      (SEGMENTS),
    .SEGMENT_BYTES (SEGMENT_BYTES)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .src (in_ch),
    .dst (out_ch),
    .cfg (cfg_ch)
  );

  // Shadow copy of the FIFO state
  logic [DATA_W-1:0]  shadow_bytes [SEGMENTS*SEGMENT_BYTES];
  bit                 shadow_written [SEGMENTS*SEGMENT_BYTES];
  logic [1:0]         wr_segment;
  logic [8:0]         wr_offset;
  logic [1:0]         rd_segment;
  logic [8:0]         rd_offset;
  logic [2:0]         occupied;
  logic [COUNT_W-1:0] byte_count;
  logic [CFG_W-1:0]   seg_len_cfg;

  sbf_res_t results_due[$];
  int       mismatches;
  int       send_idle_pct;
  int       recv_idle_pct;
  int       cycle_count;

  // Clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Hard stop if the run hangs
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Advance the shadow FIFO by one item and return the result it owes
  function automatic sbf_res_t fifo_step(logic kind, logic [DATA_W-1:0] data);
    sbf_res_t   r;
    logic [8:0] len;
    logic       starts;
    logic [9:0] addr;
    r = '0;
    len = (seg_len_cfg == '0) ? 9'd1 :
          (seg_len_cfg > SEGMENT_BYTES) ? 9'(SEGMENT_BYTES) : seg_len_cfg;
    if (kind == KIND_WRITE) begin
      starts = (wr_offset == '0);
      if (!(starts && occupied >= SEGMENTS)) begin
        addr = {wr_segment, wr_offset[7:0]};
        shadow_bytes[addr] = data;
        shadow_written[addr] = 1'b1;
        if (starts) occupied = occupied + 3'd1;
        byte_count = byte_count + 1'b1;
        wr_offset = wr_offset + 9'd1;
        if (wr_offset >= len) begin
          wr_segment = wr_segment + 2'd1;
          wr_offset = '0;
        end
        r.done_res = 1'b1;
      end
    end else if (byte_count != '0) begin
      addr = {rd_segment, rd_offset[7:0]};
      r.read_data = shadow_bytes[addr];
      byte_count = byte_count - 1'b1;
      rd_offset = rd_offset + 9'd1;
      if (rd_offset >= len) begin
        rd_segment = rd_segment + 2'd1;
        if (occupied != '0) occupied = occupied - 3'd1;
        rd_offset = '0;
      end
      r.done_res = 1'b1;
    end
    r.bytes_stored = byte_count;
    return r;
  endfunction

  // Present one item, wait until it is accepted, then queue the expected result
  task automatic send_item(logic kind, logic [DATA_W-1:0] data);
    // turn a read that would land on a never-written byte into a write
    if (kind == KIND_READ && byte_count != '0 &&
        !shadow_written[{rd_segment, rd_offset[7:0]}])
      kind = KIND_WRITE;
    forever begin
      @(negedge clk);
      if ($urandom_range(99) < send_idle_pct) begin
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= kind;
        in_ch.write_data <= data;
        break;
      end
    end
    do @(posedge clk); while (!in_ch.ready);
    results_due.push_back(fifo_step(kind, data));
  endtask

  // Hold the item channel idle until every result is back
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
  endtask

  // Write segment_length; called only with nothing in flight
  task automatic write_seg_len(logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.segment_length <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    seg_len_cfg = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Receiver stalls at random
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    sbf_res_t want;
    sbf_res_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{read_data: out_ch.read_data, done_res: out_ch.done_res,
              bytes_stored: out_ch.bytes_stored};
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: data=%h done=%b stored=%0d",
                   got.read_data, got.done_res, got.bytes_stored);
      end else begin
        want = results_due.pop_front();
        if (got.read_data !== want.read_data || got.done_res !== want.done_res ||
            got.bytes_stored !== want.bytes_stored) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want data=%h done=%b stored=%0d, got data=%h done=%b stored=%0d",
                     want.read_data, want.done_res, want.bytes_stored,
                     got.read_data, got.done_res, got.bytes_stored);
        end
      end
    end
  end

  // Empty reads, extreme bytes, plain write then read back
  task automatic test_empty_and_extremes();
    send_item(KIND_READ, 8'h00);
    send_item(KIND_WRITE, 8'h00);
    send_item(KIND_WRITE, 8'hFF);
    send_item(KIND_WRITE, 8'hA5);
    send_item(KIND_WRITE, 8'h5A);
    repeat (5) send_item(KIND_READ, 8'hFF);
    wait_drained();
  endtask

  // Length 0 acts as 1: four single-byte segments fill the ring, then writes are refused
  task automatic test_full_small_segments();
    write_seg_len(9'd0);
    send_item(KIND_WRITE, 8'h11);
    send_item(KIND_WRITE, 8'h22);
    send_item(KIND_WRITE, 8'h44);
    send_item(KIND_WRITE, 8'h88);
    send_item(KIND_WRITE, 8'hEE);
    send_item(KIND_WRITE, 8'h77);
    repeat (5) send_item(KIND_READ, 8'h00);
    wait_drained();
  endtask

  // Length above the segment size acts as the full segment; cross into the next one
  task automatic test_clamped_length();
    write_seg_len(9'd511);
    repeat (SEGMENT_BYTES + 44) send_item(KIND_WRITE, 8'($urandom_range(255)));
    repeat (SEGMENT_BYTES + 48) send_item(KIND_READ, 8'($urandom_range(255)));
    wait_drained();
  endtask

  // Shrink the segment while bytes are held past the new end
  task automatic test_resize_while_held();
    write_seg_len(9'd256);
    repeat (5) send_item(KIND_WRITE, 8'($urandom_range(255)));
    wait_drained();
    write_seg_len(9'd2);
    repeat (3) send_item(KIND_WRITE, 8'($urandom_range(255)));
    repeat (9) send_item(KIND_READ, 8'h00);
    wait_drained();
  endtask

  // Bursty read/write mix with length changes, some while data is held
  task automatic test_random_traffic(int sender_idle, int receiver_idle, int n_items);
    int sent;
    int burst_left;
    int write_pct;
    logic [CFG_W-1:0] len;
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    sent = 0;
    burst_left = 0;
    write_pct = 50;
    while (sent < n_items) begin
      if (sent % 150 == 0) begin
        wait_drained();
        case ($urandom_range(7))
          0: len = 9'd1;
          1: len = 9'd2;
          2: len = 9'd3;
          3: len = 9'd256;
          4: len = 9'($urandom_range(4, 16));
          5: len = 9'($urandom_range(17, 255));
          6: len = 9'($urandom_range(257, 511));
          default: len = 9'd0;
        endcase
        write_seg_len(len);
      end else if (sent % 150 == 75) begin
        // hold off until the block has returned everything
        wait_drained();
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(8, 60);
        write_pct = $urandom_range(10, 90);
      end
      burst_left--;
      send_item(($urandom_range(99) < write_pct) ? KIND_WRITE : KIND_READ,
                8'($urandom_range(255)));
      sent++;
    end
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_READ;
    in_ch.write_data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.segment_length = '0;
    mismatches = 0;
    send_idle_pct = 29;
    recv_idle_pct = 86;
    wr_segment = '0;
    wr_offset = '0;
    rd_segment = '0;
    rd_offset = '0;
    occupied = '0;
    byte_count = '0;
    seg_len_cfg = SEG_LEN_RESET;
    foreach (shadow_written[i]) shadow_written[i] = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_and_extremes();
    test_full_small_segments();
    test_clamped_length();
    test_resize_while_held();
    test_random_traffic(29, 86, 350);
    test_random_traffic(86, 29, 350);
    test_random_traffic(0, 0, 350);

    // let the pipeline settle before the verdict
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
